// File: hw/rtl/lsf_pkg.sv
// Package for the learning switch forwarding block: sizes, item types,
// sequencer states and port mask helpers. No dependencies.
`timescale 1ns / 1ps

package lsf_pkg;

    // Table and port sizing.
    localparam int PORTS         = 8;
    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_BITS     = 48;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = ADDR_BITS + PORTS;

    // Field widths fixed by the item formats.
    localparam int PORT_W     = 3;
    localparam int FIELD_AW   = 48;
    localparam int TAG_W      = 16;
    localparam int EGRESS_W   = 8;
    localparam int PDATA_W    = 64;
    localparam int PADDR_W    = 4;

    // Register index codes (byte address divided by eight).
    localparam logic REG_BROADCAST = 1'b0;

    localparam logic [FIELD_AW-1:0] BROADCAST_RESET = '1;

    typedef logic [PORTS-1:0] port_mask_t;

    typedef struct packed {
        logic [PORT_W-1:0]   ingress_port;
        logic [FIELD_AW-1:0] source_address;
        logic [FIELD_AW-1:0] dest_address;
        logic [TAG_W-1:0]    frame_tag;
    } in_item_t;

    typedef struct packed {
        logic [EGRESS_W-1:0] egress_mask;
        logic [TAG_W-1:0]    frame_tag_out;
        logic                dest_known;
        logic                learn_dropped;
    } out_item_t;

    // Result of the shared address comparator.
    typedef struct packed {
        logic hit_src;
        logic hit_dst;
    } match_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEARN,
        ST_RESOLVE,
        ST_DONE
    } state_t;

    localparam port_mask_t ALL_PORTS = '1;

    // Keep only the highest set bit of a port mask.
    function automatic port_mask_t highest_port_f(input port_mask_t m);
        port_mask_t r;
        r = '0;
        for (int p = 0; p < PORTS; p++) begin
            if (m[p]) begin
                r    = '0;
                r[p] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/lsf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/lsf_match.sv
// Shared address comparator: one candidate address against the source and
// destination keys of the current item. Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_match (
    input  logic [lsf_pkg::ADDR_BITS-1:0] cand_addr,
    input  logic [lsf_pkg::ADDR_BITS-1:0] src_key,
    input  logic [lsf_pkg::ADDR_BITS-1:0] dst_key,
    output lsf_pkg::match_t               result
);
    import lsf_pkg::*;

    // Equality against both keys.
    always_comb begin
        result.hit_src = (cand_addr == src_key);
        result.hit_dst = (cand_addr == dst_key);
    end

endmodule

// File: hw/rtl/learning_switch_forwarding.sv
// Top level of the learning switch forwarding block: APB register, table
// sequencer and result register. Depends on lsf_pkg, lsf_ram and lsf_match.
//
// Usage: frame headers enter on the s_ channel (valid/ready) as one item each.
// The source address is learned into a 64-entry table held in a RAM, then the
// destination is resolved to an egress port mask, returned on the m_ channel.
// After acceptance an item passes through the states scan, learn, resolve and
// done. The scan covers the cnt learned entries (0 to 64): it reads each entry
// once through the RAM port, the single comparator tests it in the cycle after
// the read against both the source and the destination, and the scan closes
// after the last compare; learn, broadcast check and result load follow in
// turn. The next item is accepted back in idle, one item at a time.
// s_ready is high only while the sequencer is idle; it does not wait for the
// result register, so a new item can start while a result waits.
// If the receiver stalls, the finished result waits in the sequencer until
// the result register frees up; nothing is dropped.
// Reset (aresetn low, synchronous) empties the table by clearing its fill
// count, sets broadcast_address to all ones and drops any pending result.
// broadcast_address lies at byte address 0 of the APB port (64-bit data);
// write it only while the block is idle.
`timescale 1ns / 1ps

module learning_switch_forwarding (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lsf_pkg::in_item_t            s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lsf_pkg::out_item_t           m_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsf_pkg::PADDR_W-1:0]  paddr,
    input  logic [lsf_pkg::PDATA_W-1:0]  pwdata,
    output logic [lsf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import lsf_pkg::*;

    state_t                 state_reg, state_next;
    logic [FIELD_AW-1:0]    bcast_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   out_valid_reg;
    logic                   cmp_vld_reg;
    out_item_t              out_item_reg;

    logic [PORT_W-1:0]      port_reg;
    logic [ADDR_BITS-1:0]   src_reg;
    logic [ADDR_BITS-1:0]   dst_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [CNT_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   src_hit_reg;
    logic [IDX_W-1:0]       src_idx_reg;
    port_mask_t             src_mask_reg;
    logic                   dst_hit_reg;
    port_mask_t             dst_mask_reg;
    logic                   dropped_reg;
    port_mask_t             egress_reg;
    logic                   known_reg;

    logic                   cfg_wr;
    logic                   out_free;
    logic                   issue;
    logic                   port_ok;
    logic                   can_append;
    port_mask_t             ingress_bit;
    port_mask_t             flood;
    port_mask_t             learn_mask;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [ADDR_BITS-1:0]   cand_addr;
    match_t                 match;

    // APB register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_BROADCAST);
    assign prdata = (paddr[PADDR_W-1] == REG_BROADCAST) ? PDATA_W'(bcast_reg) : '0;

    // Handshakes.
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;
    assign out_free = !out_valid_reg || m_ready;

    // Learning terms for the current item.
    assign port_ok     = (int'(port_reg) < PORTS);
    assign ingress_bit = port_ok ? (port_mask_t'(1) << port_reg) : '0;
    assign flood       = ALL_PORTS & ~ingress_bit;
    assign learn_mask  = src_hit_reg ? (src_mask_reg | ingress_bit) : ingress_bit;
    assign can_append  = (cnt_reg < CNT_W'(TABLE_ENTRIES));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!issue && !cmp_vld_reg) state_next = ST_LEARN;
            end
            ST_LEARN: begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: RAM controls and comparator input select.
    always_comb begin
        issue     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = src_hit_reg ? src_idx_reg : cnt_reg[IDX_W-1:0];
        ram_wdata = {src_reg, learn_mask};
        cand_addr = bcast_reg[ADDR_BITS-1:0];
        case (state_reg)
            ST_SCAN: begin
                issue     = (rd_idx_reg < cnt_reg);
                cand_addr = ram_rdata[ENTRY_W-1 -: ADDR_BITS];
            end
            ST_LEARN: begin
                ram_we    = port_ok && (src_hit_reg || can_append);
                cand_addr = src_reg;
            end
            default: begin
                cand_addr = bcast_reg[ADDR_BITS-1:0];
            end
        endcase
    end

    lsf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    lsf_match u_match (
        .cand_addr (cand_addr),
        .src_key   (src_reg),
        .dst_key   (dst_reg),
        .result    (match)
    );

    // Control state: sequencer, fill count, register, result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bcast_reg     <= BROADCAST_RESET;
            out_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= issue;
            if (cfg_wr) begin
                bcast_reg <= pwdata[FIELD_AW-1:0];
            end
            if (state_reg == ST_LEARN && port_ok && !src_hit_reg && can_append) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    port_reg    <= s_item.ingress_port;
                    src_reg     <= s_item.source_address[ADDR_BITS-1:0];
                    dst_reg     <= s_item.dest_address[ADDR_BITS-1:0];
                    tag_reg     <= s_item.frame_tag;
                    rd_idx_reg  <= '0;
                    src_hit_reg <= 1'b0;
                    dst_hit_reg <= 1'b0;
                    dropped_reg <= 1'b0;
                end
            end
            ST_SCAN: begin
                cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
                if (issue) begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                // Entry read last cycle is now at the comparator.
                if (cmp_vld_reg) begin
                    if (match.hit_src) begin
                        src_hit_reg  <= 1'b1;
                        src_idx_reg  <= cmp_idx_reg;
                        src_mask_reg <= ram_rdata[PORTS-1:0];
                    end
                    if (match.hit_dst) begin
                        dst_hit_reg  <= 1'b1;
                        dst_mask_reg <= ram_rdata[PORTS-1:0];
                    end
                end
            end
            ST_LEARN: begin
                if (port_ok && !src_hit_reg && !can_append) begin
                    dropped_reg <= 1'b1;
                end
                // Destination equal to the source sees the freshly learned mask.
                if (ram_we && match.hit_dst) begin
                    dst_hit_reg  <= 1'b1;
                    dst_mask_reg <= learn_mask;
                end
            end
            ST_RESOLVE: begin
                // Broadcast wins over a table hit.
                if (match.hit_dst) begin
                    egress_reg <= flood;
                    known_reg  <= 1'b0;
                end else if (dst_hit_reg && (dst_mask_reg & ALL_PORTS) != '0) begin
                    egress_reg <= highest_port_f(dst_mask_reg & ALL_PORTS);
                    known_reg  <= 1'b1;
                end else begin
                    egress_reg <= flood;
                    known_reg  <= 1'b0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_item_reg.egress_mask   <= EGRESS_W'(egress_reg);
                    out_item_reg.frame_tag_out <= tag_reg;
                    out_item_reg.dest_known    <= known_reg;
                    out_item_reg.learn_dropped <= dropped_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for learning_switch_forwarding: directed frame table,
// then random frame traffic with a learning-table predictor and APB writes.
// Depends on lsf_pkg and the learning_switch_forwarding RTL.
`timescale 1ns / 1ps

module tb_top;

    import lsf_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 9;
    localparam int TIMEOUT_NS   = 8_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_SIZE    = 96;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 242;
    localparam int STALL_AT     = 600;
    localparam int LONG_STALL   = 700;
    localparam int SETTLE       = 8;
    localparam int TAIL_CYCLES  = 80;

    localparam logic [FIELD_AW-1:0] ADDR_KEEP  = {FIELD_AW{1'b1}} >> (FIELD_AW - ADDR_BITS);
    localparam logic [FIELD_AW-1:0] ADDR_ONES  = '1;
    localparam logic [FIELD_AW-1:0] ADDR_ZERO  = '0;
    localparam logic [FIELD_AW-1:0] ADDR_A     = 48'h0200_5E10_0001;
    localparam logic [FIELD_AW-1:0] ADDR_B     = 48'hA5A5_A5A5_A5A5;
    localparam logic [FIELD_AW-1:0] ADDR_C     = 48'h5A5A_5A5A_5A5A;
    localparam logic [FIELD_AW-1:0] ADDR_D     = 48'h8000_0000_0000;

    typedef enum logic [0:0] {
        ROW_FRAME,
        ROW_BCAST
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        in_item_t            frame;
        logic [FIELD_AW-1:0] bcast;
        bit                  typed;
        out_item_t           want;
    } frame_row_t;

    // DUT connections.
    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_item;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predictor state: a mirror of the address table and the broadcast register.
    logic [FIELD_AW-1:0] learned_addr [TABLE_ENTRIES];
    port_mask_t          learned_ports [TABLE_ENTRIES];
    int                  learned_count;
    logic [FIELD_AW-1:0] bcast_addr;

    out_item_t           pending_forwards [$];
    frame_row_t          directed_rows [$];
    logic [FIELD_AW-1:0] addr_pool [POOL_SIZE];
    logic [FIELD_AW-1:0] phase_bcast [PHASES];
    int                  fail_count = 0;
    int                  frames_accepted = 0;
    bit                  stall_request = 1'b0;
    bit                  stall_done = 1'b0;

    learning_switch_forwarding dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // Random idle length: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 100);
    endfunction

    function automatic logic [FIELD_AW-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[FIELD_AW-1:0];
    endfunction

    // Index of the table entry holding addr, or -1.
    function automatic int table_index(logic [FIELD_AW-1:0] addr);
        for (int i = 0; i < learned_count; i++) begin
            if (learned_addr[i] == addr) return i;
        end
        return -1;
    endfunction

    // Learn the source, then resolve the destination to an egress mask.
    function automatic out_item_t forward_predict(in_item_t it);
        out_item_t           res;
        logic [FIELD_AW-1:0] src;
        logic [FIELD_AW-1:0] dst;
        port_mask_t          ingress_bit;
        port_mask_t          flood;
        port_mask_t          egress;
        port_mask_t          seen;
        bit                  port_ok;
        bit                  known;
        bit                  dropped;
        int                  k;
        src         = it.source_address & ADDR_KEEP;
        dst         = it.dest_address & ADDR_KEEP;
        port_ok     = int'(it.ingress_port) < PORTS;
        ingress_bit = port_ok ? (port_mask_t'(1) << it.ingress_port) : '0;
        flood       = ~ingress_bit;
        known       = 1'b0;
        dropped     = 1'b0;

        if (port_ok) begin
            k = table_index(src);
            if (k >= 0) begin
                learned_ports[k] |= ingress_bit;
            end else if (learned_count < TABLE_ENTRIES) begin
                learned_addr[learned_count]  = src;
                learned_ports[learned_count] = ingress_bit;
                learned_count++;
            end else begin
                dropped = 1'b1;
            end
        end

        egress = flood;
        if (dst != (bcast_addr & ADDR_KEEP)) begin
            k = table_index(dst);
            if (k >= 0 && learned_ports[k] != '0) begin
                // Only the highest-numbered port that has seen the address.
                seen   = learned_ports[k];
                egress = '0;
                for (int p = PORTS - 1; p >= 0; p--) begin
                    if (seen[p] && egress == '0) egress[p] = 1'b1;
                end
                known = 1'b1;
            end
        end

        res.egress_mask   = EGRESS_W'(egress);
        res.frame_tag_out = it.frame_tag;
        res.dest_known    = known;
        res.learn_dropped = dropped;
        return res;
    endfunction

    function automatic frame_row_t frame_row(logic [PORT_W-1:0] port,
                                             logic [FIELD_AW-1:0] src,
                                             logic [FIELD_AW-1:0] dst,
                                             logic [TAG_W-1:0] tag);
        frame_row_t row;
        row.kind                 = ROW_FRAME;
        row.frame.ingress_port   = port;
        row.frame.source_address = src;
        row.frame.dest_address   = dst;
        row.frame.frame_tag      = tag;
        row.bcast                = '0;
        row.typed                = 1'b0;
        row.want                 = '0;
        return row;
    endfunction

    function automatic frame_row_t checked_row(logic [PORT_W-1:0] port,
                                               logic [FIELD_AW-1:0] src,
                                               logic [FIELD_AW-1:0] dst,
                                               logic [TAG_W-1:0] tag,
                                               logic [EGRESS_W-1:0] egress,
                                               logic known);
        frame_row_t row;
        row                    = frame_row(port, src, dst, tag);
        row.typed              = 1'b1;
        row.want.egress_mask   = egress;
        row.want.frame_tag_out = tag;
        row.want.dest_known    = known;
        row.want.learn_dropped = 1'b0;
        return row;
    endfunction

    function automatic frame_row_t bcast_row(logic [FIELD_AW-1:0] value);
        frame_row_t row;
        row       = frame_row('0, '0, '0, '0);
        row.kind  = ROW_BCAST;
        row.bcast = value;
        return row;
    endfunction

    // Append one row to the end of the directed table.
    task automatic add_row(frame_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Offer one item, hold it until accepted, then idle for a random gap (possibly none) unless no_idle is set.
    task automatic send_frame(in_item_t it, bit typed, out_item_t want, bit no_idle);
        out_item_t predicted;
        int        gap;
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = forward_predict(it);
        pending_forwards.insert(pending_forwards.size(), typed ? want : predicted);
        frames_accepted++;
        if (frames_accepted == STALL_AT) stall_request = 1'b1;
        gap = no_idle ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic quiesce(int settle);
        s_valid <= 1'b0;
        while (pending_forwards.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // APB write of the broadcast register: setup cycle, then access cycle.
    task automatic write_broadcast(logic [FIELD_AW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_BROADCAST) << 3;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bcast_addr = value;
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_forwards.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: egress %h tag %h known %b dropped %b",
                             m_item.egress_mask, m_item.frame_tag_out,
                             m_item.dest_known, m_item.learn_dropped);
            end else begin
                want = pending_forwards.pop_front();
                if (m_item.egress_mask !== want.egress_mask ||
                    m_item.frame_tag_out !== want.frame_tag_out ||
                    m_item.dest_known !== want.dest_known ||
                    m_item.learn_dropped !== want.learn_dropped) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: exp egress %h tag %h known %b dropped %b, %s",
                                 want.egress_mask, want.frame_tag_out, want.dest_known,
                                 want.learn_dropped,
                                 $sformatf("got egress %h tag %h known %b dropped %b",
                                           m_item.egress_mask, m_item.frame_tag_out,
                                           m_item.dest_known, m_item.learn_dropped));
                end
            end
        end
    end

    // Receiver: random ready pattern, plus one long hold-off to back up the block.
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (stall_request && !stall_done) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                stall_done = 1'b1;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 3)
                    repeat ($urandom_range(300, 1500)) @(posedge aclk);
                else
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                gap = idle_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

    // Main stimulus: reset, directed table, then random phases.
    initial begin : frame_source
        in_item_t            it;
        logic [FIELD_AW-1:0] src;
        int                  grow;
        int                  r;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        learned_count = 0;
        bcast_addr    = BROADCAST_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            learned_addr[i]  = '0;
            learned_ports[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
        addr_pool[0] = ADDR_ONES;
        addr_pool[1] = ADDR_ZERO;
        phase_bcast = '{ADDR_ONES, rand_addr(), addr_pool[3], ADDR_ZERO, rand_addr(), ADDR_ONES};

        // Directed rows: port extremes, broadcast, back to ingress, broadcast wins.
        add_row(checked_row(3'd0, ADDR_A, ADDR_ONES, 16'h0000, 8'hFE, 1'b0));
        add_row(checked_row(3'd7, ADDR_ONES, ADDR_ZERO, 16'hFFFF, 8'h7F, 1'b0));
        add_row(checked_row(3'd3, ADDR_ZERO, ADDR_A, 16'h1234, 8'h01, 1'b1));
        add_row(checked_row(3'd5, ADDR_A, ADDR_A, 16'h0005, 8'h20, 1'b1));
        add_row(checked_row(3'd2, ADDR_B, ADDR_B, 16'h0006, 8'h04, 1'b1));
        add_row(checked_row(3'd1, ADDR_C, ADDR_ONES, 16'h0007, 8'hFD, 1'b0));
        add_row(checked_row(3'd6, ADDR_ZERO, ADDR_ZERO, 16'h0008, 8'h40, 1'b1));
        add_row(checked_row(3'd4, ADDR_D, ADDR_C, 16'h0009, 8'h02, 1'b1));
        add_row(frame_row(3'd7, ADDR_C, ADDR_B, 16'hBEEF));
        add_row(frame_row(3'd0, ADDR_B, ADDR_C, 16'h00FF));
        // A learned address set as broadcast floods; the all-ones address is now known.
        add_row(bcast_row(ADDR_A));
        add_row(checked_row(3'd4, ADDR_D, ADDR_A, 16'h000B, 8'hEF, 1'b0));
        add_row(checked_row(3'd2, ADDR_C, ADDR_ONES, 16'h000C, 8'h80, 1'b1));
        add_row(bcast_row(ADDR_ZERO));
        add_row(checked_row(3'd0, ADDR_A, ADDR_ZERO, 16'h000E, 8'hFE, 1'b0));
        add_row(frame_row(3'd3, ADDR_ZERO, ADDR_D, 16'hFF00));
        add_row(bcast_row(ADDR_ONES));
        add_row(frame_row(3'd5, 48'h0000_FFFF_0000, 48'hFFFF_0000_FFFF, 16'h8000));
        add_row(frame_row(3'd6, 48'h1234_5678_9ABC, ADDR_A, 16'h7FFF));
        add_row(checked_row(3'd7, ADDR_D, ADDR_D, 16'h0014, 8'h80, 1'b1));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_BCAST) begin
                quiesce(SETTLE);
                write_broadcast(directed_rows[i].bcast);
            end else begin
                send_frame(directed_rows[i].frame, directed_rows[i].typed,
                           directed_rows[i].want, 1'b0);
            end
        end

        // Random phases, each under its own broadcast setting. The source pool
        // widens over time so the table fills gradually and then overflows.
        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce(SETTLE);
            write_broadcast(phase_bcast[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                grow = 6 + frames_accepted / 6;
                if (grow > POOL_SIZE - 1) grow = POOL_SIZE - 1;
                r = $urandom_range(0, 99);
                src = (r < 88) ? addr_pool[$urandom_range(0, grow)] : rand_addr();
                it.ingress_port   = PORT_W'($urandom_range(0, 7));
                it.source_address = src;
                it.frame_tag      = TAG_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 55)
                    it.dest_address = addr_pool[$urandom_range(0, grow)];
                else if (r < 70)
                    it.dest_address = bcast_addr;
                else if (r < 85)
                    it.dest_address = src;
                else
                    it.dest_address = rand_addr();
                send_frame(it, 1'b0, '0, ph == 1);
            end
        end

        quiesce(TAIL_CYCLES);
        if (fail_count == 0 && pending_forwards.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
